FILE: hdl/arp_pkg.sv
// Package for the point rotator: word types, stage types, widths and the sine table.
`default_nettype none
package arp_pkg;

    // Field widths of the words
    localparam int COORD_W = 32;
    localparam int OP_W    = 2;
    localparam int ANGLE_W = 12;

    // Angle and fraction resolution
    localparam int ANGLE_BITS = 12;
    localparam int FRAC_BITS  = 16;

    // Quarter-wave table geometry
    localparam int QBITS   = ANGLE_BITS - 2;
    localparam int QUARTER = 1 << QBITS;
    localparam int IDX_W   = QBITS + 1;
    localparam int MAG_W   = FRAC_BITS + 1;
    localparam int TRIG_W  = FRAC_BITS + 2;

    // Datapath widths
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + TRIG_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int RND_W  = SUM_W - FRAC_BITS;
    localparam int NEW_W  = RND_W + 1;

    // Axis codes
    localparam logic [OP_W-1:0] AXIS_X    = OP_W'(0);
    localparam logic [OP_W-1:0] AXIS_Y    = OP_W'(1);
    localparam logic [OP_W-1:0] AXIS_Z    = OP_W'(2);
    localparam logic [OP_W-1:0] AXIS_NONE = OP_W'(3);

    // Rounding offset and saturation limits
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [NEW_W-1:0] SAT_MAX =
        NEW_W'({1'b0, {(COORD_W-1){1'b1}}});
    localparam logic signed [NEW_W-1:0] SAT_MIN =
        -NEW_W'({1'b1, {(COORD_W-1){1'b0}}});

    // pi/2 in Q2.30
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic signed [COORD_W-1:0] pivot_x;
        logic signed [COORD_W-1:0] pivot_y;
        logic signed [COORD_W-1:0] pivot_z;
        logic [ANGLE_W-1:0]        angle;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_W-1:0] rotated_x;
        logic signed [COORD_W-1:0] rotated_y;
        logic signed [COORD_W-1:0] rotated_z;
        logic                      saturated;
    } t_out_word;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_vec;

    // After pivot subtract and angle fold
    typedef struct packed {
        logic [OP_W-1:0]           op;
        t_vec                      pt;
        logic signed [COORD_W-1:0] pa;
        logic signed [COORD_W-1:0] pb;
        logic signed [DIFF_W-1:0]  da;
        logic signed [DIFF_W-1:0]  db;
        logic [IDX_W-1:0]          sin_idx;
        logic                      sin_neg;
        logic [IDX_W-1:0]          cos_idx;
        logic                      cos_neg;
    } t_s1;

    // After table lookup
    typedef struct packed {
        logic [OP_W-1:0]           op;
        t_vec                      pt;
        logic signed [COORD_W-1:0] pa;
        logic signed [COORD_W-1:0] pb;
        logic signed [DIFF_W-1:0]  da;
        logic signed [DIFF_W-1:0]  db;
        logic signed [TRIG_W-1:0]  s;
        logic signed [TRIG_W-1:0]  c;
    } t_s2;

    // After the four products
    typedef struct packed {
        logic [OP_W-1:0]           op;
        t_vec                      pt;
        logic signed [COORD_W-1:0] pa;
        logic signed [COORD_W-1:0] pb;
        logic signed [PROD_W-1:0]  p_ac;
        logic signed [PROD_W-1:0]  p_bs;
        logic signed [PROD_W-1:0]  p_as;
        logic signed [PROD_W-1:0]  p_bc;
    } t_s3;

    // After sum and rounding
    typedef struct packed {
        logic [OP_W-1:0]           op;
        t_vec                      pt;
        logic signed [COORD_W-1:0] pa;
        logic signed [COORD_W-1:0] pb;
        logic signed [RND_W-1:0]   ra;
        logic signed [RND_W-1:0]   rb;
    } t_s4;

    typedef logic [MAG_W-1:0] t_sine_tab [QUARTER+1];

    // One quarter-wave entry: Taylor series in Q30, rounded to FRAC_BITS
    function automatic logic [MAG_W-1:0] sine_entry(input longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sm;
        x    = (r * HALF_PI_Q30 + ((64'd1 << QBITS) >> 1)) >> QBITS;
        x2   = (x * x) >> 30;
        term = x;
        sm   = longint'(x);
        term = ((term * x2) >> 30) / 6;
        sm   = sm - longint'(term);
        term = ((term * x2) >> 30) / 20;
        sm   = sm + longint'(term);
        term = ((term * x2) >> 30) / 42;
        sm   = sm - longint'(term);
        term = ((term * x2) >> 30) / 72;
        sm   = sm + longint'(term);
        term = ((term * x2) >> 30) / 110;
        sm   = sm - longint'(term);
        term = ((term * x2) >> 30) / 156;
        sm   = sm + longint'(term);
        term = ((term * x2) >> 30) / 210;
        sm   = sm - longint'(term);
        if (sm < 0) begin
            sm = 0;
        end
        sm = (sm + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        if (sm > (longint'(1) <<< FRAC_BITS)) begin
            sm = longint'(1) <<< FRAC_BITS;
        end
        return MAG_W'(sm);
    endfunction

    function automatic t_sine_tab build_sine_tab();
        t_sine_tab tab;
        for (int i = 0; i <= QUARTER; i++) begin
            tab[i] = sine_entry(longint'(i));
        end
        return tab;
    endfunction

    // Quarter-wave sine magnitudes, indices 0 to QUARTER inclusive
    localparam t_sine_tab SINE_TAB = build_sine_tab();

endpackage
`default_nettype wire

FILE: hdl/arp_prep.sv
// First stage: input register, pivot subtract, axis select and angle fold.
`default_nettype none
module arp_prep (
    input  wire                     logic i_clk,
    input  wire                     logic i_rst_n,
    input  wire                     logic i_valid,
    input  wire arp_pkg::t_in_word  i_word,
    output logic                    o_ready,
    output logic                    o_valid,
    output arp_pkg::t_s1            o_s1,
    input  wire                     logic i_ready
);

    logic                                 r_valid;
    arp_pkg::t_s1                         r_s1;
    arp_pkg::t_s1                         n_s1;
    logic [arp_pkg::ANGLE_BITS-1:0]       ang;
    logic [1:0]                           quad;
    logic [arp_pkg::IDX_W-1:0]            idx_fwd;
    logic [arp_pkg::IDX_W-1:0]            idx_rev;
    logic signed [arp_pkg::COORD_W-1:0]   a_pt;
    logic signed [arp_pkg::COORD_W-1:0]   b_pt;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_s1    = r_s1;

    // Fold the angle into a quarter-wave index for sine and cosine
    always_comb begin
        ang     = arp_pkg::ANGLE_BITS'(i_word.angle);
        quad    = ang[arp_pkg::ANGLE_BITS-1 -: 2];
        idx_fwd = arp_pkg::IDX_W'(ang[arp_pkg::QBITS-1:0]);
        idx_rev = arp_pkg::IDX_W'(arp_pkg::QUARTER) - idx_fwd;
    end

    // Pick the coordinate pair that the axis turns
    always_comb begin
        n_s1.op   = i_word.operation;
        n_s1.pt.x = i_word.point_x;
        n_s1.pt.y = i_word.point_y;
        n_s1.pt.z = i_word.point_z;
        case (i_word.operation)
            arp_pkg::AXIS_X: begin
                a_pt    = i_word.point_y;
                b_pt    = i_word.point_z;
                n_s1.pa = i_word.pivot_y;
                n_s1.pb = i_word.pivot_z;
            end
            arp_pkg::AXIS_Y: begin
                a_pt    = i_word.point_x;
                b_pt    = i_word.point_z;
                n_s1.pa = i_word.pivot_x;
                n_s1.pb = i_word.pivot_z;
            end
            default: begin
                a_pt    = i_word.point_x;
                b_pt    = i_word.point_y;
                n_s1.pa = i_word.pivot_x;
                n_s1.pb = i_word.pivot_y;
            end
        endcase
        n_s1.da      = arp_pkg::DIFF_W'(a_pt) - arp_pkg::DIFF_W'(n_s1.pa);
        n_s1.db      = arp_pkg::DIFF_W'(b_pt) - arp_pkg::DIFF_W'(n_s1.pb);
        n_s1.sin_idx = quad[0] ? idx_rev : idx_fwd;
        n_s1.sin_neg = quad[1];
        n_s1.cos_idx = quad[0] ? idx_fwd : idx_rev;
        n_s1.cos_neg = quad[1] ^ quad[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready) begin
            r_s1 <= n_s1;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/arp_sincos.sv
// Second stage: registered sine and cosine lookup from the quarter-wave table.
`default_nettype none
module arp_sincos (
    input  wire               logic i_clk,
    input  wire               logic i_rst_n,
    input  wire               logic i_valid,
    input  wire arp_pkg::t_s1 i_s1,
    output logic              o_ready,
    output logic              o_valid,
    output arp_pkg::t_s2      o_s2,
    input  wire               logic i_ready
);

    logic                                r_valid;
    arp_pkg::t_s2                        r_s2;
    arp_pkg::t_s2                        n_s2;
    logic signed [arp_pkg::TRIG_W-1:0]   s_pos;
    logic signed [arp_pkg::TRIG_W-1:0]   c_pos;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_s2    = r_s2;

    // Two table reads, then the quadrant sign
    always_comb begin
        s_pos   = $signed(arp_pkg::TRIG_W'(arp_pkg::SINE_TAB[i_s1.sin_idx]));
        c_pos   = $signed(arp_pkg::TRIG_W'(arp_pkg::SINE_TAB[i_s1.cos_idx]));
        n_s2.op = i_s1.op;
        n_s2.pt = i_s1.pt;
        n_s2.pa = i_s1.pa;
        n_s2.pb = i_s1.pb;
        n_s2.da = i_s1.da;
        n_s2.db = i_s1.db;
        n_s2.s  = i_s1.sin_neg ? -s_pos : s_pos;
        n_s2.c  = i_s1.cos_neg ? -c_pos : c_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready) begin
            r_s2 <= n_s2;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/arp_rotate.sv
// Third and fourth stages: the four products, then the sums with rounding.
`default_nettype none
module arp_rotate (
    input  wire               logic i_clk,
    input  wire               logic i_rst_n,
    input  wire               logic i_valid,
    input  wire arp_pkg::t_s2 i_s2,
    output logic              o_ready,
    output logic              o_valid,
    output arp_pkg::t_s4      o_s4,
    input  wire               logic i_ready
);

    logic                               r_v3;
    logic                               r_v4;
    arp_pkg::t_s3                       r_s3;
    arp_pkg::t_s4                       r_s4;
    arp_pkg::t_s3                       n_s3;
    arp_pkg::t_s4                       n_s4;
    logic                               rdy3;
    logic                               rdy4;
    logic signed [arp_pkg::SUM_W-1:0]   sum_a;
    logic signed [arp_pkg::SUM_W-1:0]   sum_b;

    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign o_ready = rdy3;
    assign o_valid = r_v4;
    assign o_s4    = r_s4;

    // Products of the differences with sine and cosine
    always_comb begin
        n_s3.op   = i_s2.op;
        n_s3.pt   = i_s2.pt;
        n_s3.pa   = i_s2.pa;
        n_s3.pb   = i_s2.pb;
        n_s3.p_ac = arp_pkg::PROD_W'(i_s2.da * i_s2.c);
        n_s3.p_bs = arp_pkg::PROD_W'(i_s2.db * i_s2.s);
        n_s3.p_as = arp_pkg::PROD_W'(i_s2.da * i_s2.s);
        n_s3.p_bc = arp_pkg::PROD_W'(i_s2.db * i_s2.c);
    end

    // a' = da*c - db*s, b' = da*s + db*c, rounded half up
    always_comb begin
        sum_a   = arp_pkg::SUM_W'(r_s3.p_ac) - arp_pkg::SUM_W'(r_s3.p_bs)
                  + arp_pkg::ROUND_HALF;
        sum_b   = arp_pkg::SUM_W'(r_s3.p_as) + arp_pkg::SUM_W'(r_s3.p_bc)
                  + arp_pkg::ROUND_HALF;
        n_s4.op = r_s3.op;
        n_s4.pt = r_s3.pt;
        n_s4.pa = r_s3.pa;
        n_s4.pb = r_s3.pb;
        n_s4.ra = arp_pkg::RND_W'(sum_a >>> arp_pkg::FRAC_BITS);
        n_s4.rb = arp_pkg::RND_W'(sum_b >>> arp_pkg::FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy3) begin
                r_v3 <= i_valid;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
        if (rdy3) begin
            r_s3 <= n_s3;
        end
        if (rdy4) begin
            r_s4 <= n_s4;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/axis_rotate_about_pivot.sv
// Top level of the point rotator: stage chain, pivot add-back, saturation, output word.
`default_nettype none
// Rotates a Q16.16 point about the x, y or z axis through a pivot by a binary angle
// (4096 steps a turn) and returns the saturated result with a clip flag; axis code three
// passes the point through. Fully pipelined: one word enters and one leaves every cycle
// while the output is not stalled; a word passes the registered stages in order (input
// register and pivot subtract, sine/cosine table read, products, sums and rounding,
// pivot add and saturation). The sine/cosine lookup is a registered read of a
// 1025-entry quarter-wave constant table. A stall on the output holds the chain in
// place; bubbles are squeezed out, so o_stall rises only when every stage holds a word.
module axis_rotate_about_pivot (
    input  wire                     logic i_clk,
    input  wire                     logic i_rst_n,
    input  wire                     logic i_valid,
    input  wire arp_pkg::t_in_word  i_word,
    output logic                    o_stall,
    output logic                    o_valid,
    output arp_pkg::t_out_word      o_word,
    input  wire                     logic i_stall
);

    logic                               s1_ready;
    logic                               s1_valid;
    arp_pkg::t_s1                       s1;
    logic                               s2_ready;
    logic                               s2_valid;
    arp_pkg::t_s2                       s2;
    logic                               s4_ready;
    logic                               s4_valid;
    arp_pkg::t_s4                       s4;
    logic                               s5_ready;
    logic                               r_valid;
    arp_pkg::t_out_word                 r_out;
    arp_pkg::t_out_word                 n_out;
    logic signed [arp_pkg::NEW_W-1:0]   na;
    logic signed [arp_pkg::NEW_W-1:0]   nb;
    logic signed [arp_pkg::COORD_W-1:0] ca;
    logic signed [arp_pkg::COORD_W-1:0] cb;
    logic                               clip_a;
    logic                               clip_b;

    arp_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_word  (i_word),
        .o_ready (s1_ready),
        .o_valid (s1_valid),
        .o_s1    (s1),
        .i_ready (s2_ready)
    );

    arp_sincos u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .i_s1    (s1),
        .o_ready (s2_ready),
        .o_valid (s2_valid),
        .o_s2    (s2),
        .i_ready (s4_ready)
    );

    arp_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .i_s2    (s2),
        .o_ready (s4_ready),
        .o_valid (s4_valid),
        .o_s4    (s4),
        .i_ready (s5_ready)
    );

    assign s5_ready = !r_valid || !i_stall;
    assign o_stall  = !s1_ready;
    assign o_valid  = r_valid;
    assign o_word   = r_out;

    // Add the pivot back and clip to 32 bits
    always_comb begin
        na     = arp_pkg::NEW_W'(s4.ra) + arp_pkg::NEW_W'(s4.pa);
        nb     = arp_pkg::NEW_W'(s4.rb) + arp_pkg::NEW_W'(s4.pb);
        clip_a = (na > arp_pkg::SAT_MAX) || (na < arp_pkg::SAT_MIN);
        clip_b = (nb > arp_pkg::SAT_MAX) || (nb < arp_pkg::SAT_MIN);
        if (na > arp_pkg::SAT_MAX) begin
            ca = arp_pkg::COORD_W'(arp_pkg::SAT_MAX);
        end else if (na < arp_pkg::SAT_MIN) begin
            ca = arp_pkg::COORD_W'(arp_pkg::SAT_MIN);
        end else begin
            ca = arp_pkg::COORD_W'(na);
        end
        if (nb > arp_pkg::SAT_MAX) begin
            cb = arp_pkg::COORD_W'(arp_pkg::SAT_MAX);
        end else if (nb < arp_pkg::SAT_MIN) begin
            cb = arp_pkg::COORD_W'(arp_pkg::SAT_MIN);
        end else begin
            cb = arp_pkg::COORD_W'(nb);
        end
    end

    // Put the turned pair back in place of the original coordinates
    always_comb begin
        n_out.rotated_x = s4.pt.x;
        n_out.rotated_y = s4.pt.y;
        n_out.rotated_z = s4.pt.z;
        n_out.saturated = 1'b0;
        case (s4.op)
            arp_pkg::AXIS_X: begin
                n_out.rotated_y = ca;
                n_out.rotated_z = cb;
                n_out.saturated = clip_a || clip_b;
            end
            arp_pkg::AXIS_Y: begin
                n_out.rotated_x = ca;
                n_out.rotated_z = cb;
                n_out.saturated = clip_a || clip_b;
            end
            arp_pkg::AXIS_Z: begin
                n_out.rotated_x = ca;
                n_out.rotated_y = cb;
                n_out.saturated = clip_a || clip_b;
            end
            default: begin
                n_out.saturated = 1'b0;
            end
        endcase
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s5_ready) begin
            r_valid <= s4_valid;
        end
        if (s5_ready) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    // A clipped word has at least one coordinate at a range limit
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.saturated) |->
        (r_out.rotated_x == arp_pkg::COORD_W'(arp_pkg::SAT_MAX)) ||
        (r_out.rotated_x == arp_pkg::COORD_W'(arp_pkg::SAT_MIN)) ||
        (r_out.rotated_y == arp_pkg::COORD_W'(arp_pkg::SAT_MAX)) ||
        (r_out.rotated_y == arp_pkg::COORD_W'(arp_pkg::SAT_MIN)) ||
        (r_out.rotated_z == arp_pkg::COORD_W'(arp_pkg::SAT_MAX)) ||
        (r_out.rotated_z == arp_pkg::COORD_W'(arp_pkg::SAT_MIN)))
        else $error("saturated flag set with no coordinate at a limit");

    // A held word in the first stage is not dropped
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && !s2_ready) |=> s1_valid)
        else $error("first stage lost a word under stall");

    // The input side never stalls while the first stage is empty
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_valid |-> !o_stall)
        else $error("input stalled with an empty first stage");

    // A pass-through word never reports clipping
    a_pass_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s4_valid && (s4.op == arp_pkg::AXIS_NONE) && s5_ready) |=>
        (r_valid && !r_out.saturated))
        else $error("pass-through word flagged as saturated");
`endif

endmodule
`default_nettype wire

FILE: verif/axis_rotate_about_pivot_tb.sv
// Testbench for the point rotator: directed and random words checked against a behavioral model.
`default_nettype none
module axis_rotate_about_pivot_tb;

    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
    localparam int QTR_TURN = 1 << (arp_pkg::ANGLE_BITS - 2);
    localparam logic signed [arp_pkg::COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [arp_pkg::COORD_W-1:0] C_MIN = 32'sh8000_0000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    arp_pkg::t_in_word  i_word;
    logic               o_stall;
    logic               o_valid;
    arp_pkg::t_out_word o_word;
    logic               i_stall;

    // rotated points still in flight, oldest first
    arp_pkg::t_out_word rotation_queue[$];
    arp_pkg::t_out_word want_word;
    int unsigned        error_count = 0;
    bit                 idle_on     = 1'b1;

    axis_rotate_about_pivot DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Behavioral model of the rotator
    // ---------------------------------------------------------------

    // quarter-wave sine magnitude: Taylor series in Q30, rounded to the fraction width
    function automatic longint quarter_sine(input longint unsigned r);
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint          acc;
        ang    = (r * PI_HALF_Q30 + (64'd1 << (arp_pkg::ANGLE_BITS - 3)))
                 >> (arp_pkg::ANGLE_BITS - 2);
        ang_sq = (ang * ang) >> 30;
        term   = ang;
        acc    = longint'(ang);
        for (int k = 1; k <= 7; k++) begin
            term = ((term * ang_sq) >> 30) / 64'(4 * k * k + 2 * k);
            if (k % 2 == 1) begin
                acc -= longint'(term);
            end else begin
                acc += longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        acc = (acc + (longint'(1) <<< (29 - arp_pkg::FRAC_BITS))) >>> (30 - arp_pkg::FRAC_BITS);
        if (acc > (longint'(1) <<< arp_pkg::FRAC_BITS)) begin
            acc = longint'(1) <<< arp_pkg::FRAC_BITS;
        end
        return acc;
    endfunction

    // full-turn sine from quadrant symmetry
    function automatic longint turn_sine(input logic [arp_pkg::ANGLE_W-1:0] a);
        logic [1:0]      quad;
        longint unsigned r;
        quad = a[arp_pkg::ANGLE_BITS-1 -: 2];
        r    = 64'(a[arp_pkg::ANGLE_BITS-3:0]);
        case (quad)
            2'd0:    return quarter_sine(r);
            2'd1:    return quarter_sine(64'(QTR_TURN) - r);
            2'd2:    return -quarter_sine(r);
            default: return -quarter_sine(64'(QTR_TURN) - r);
        endcase
    endfunction

    function automatic longint clip32(input longint v, inout bit clipped);
        if (v > longint'(C_MAX)) begin
            clipped = 1'b1;
            return longint'(C_MAX);
        end
        if (v < longint'(C_MIN)) begin
            clipped = 1'b1;
            return longint'(C_MIN);
        end
        return v;
    endfunction

    // a' = da*c - db*s, b' = da*s + db*c, rounded half up, pivot added back
    function automatic void turn_pair(inout longint a, inout longint b,
                                      input longint pa, input longint pb,
                                      input longint s, input longint c,
                                      inout bit clipped);
        longint da;
        longint db;
        longint half;
        da   = a - pa;
        db   = b - pb;
        half = longint'(1) <<< (arp_pkg::FRAC_BITS - 1);
        a    = clip32(((da * c - db * s + half) >>> arp_pkg::FRAC_BITS) + pa, clipped);
        b    = clip32(((da * s + db * c + half) >>> arp_pkg::FRAC_BITS) + pb, clipped);
    endfunction

    function automatic arp_pkg::t_out_word predict_rotation(input arp_pkg::t_in_word w);
        longint                      vx;
        longint                      vy;
        longint                      vz;
        longint                      s;
        longint                      c;
        logic [arp_pkg::ANGLE_W-1:0] cos_ang;
        bit                          clipped;
        arp_pkg::t_out_word          r;
        vx      = w.point_x;
        vy      = w.point_y;
        vz      = w.point_z;
        clipped = 1'b0;
        cos_ang = w.angle + arp_pkg::ANGLE_W'(QTR_TURN);
        s       = turn_sine(w.angle);
        c       = turn_sine(cos_ang);
        case (w.operation)
            arp_pkg::AXIS_X: turn_pair(vy, vz, w.pivot_y, w.pivot_z, s, c, clipped);
            arp_pkg::AXIS_Y: turn_pair(vx, vz, w.pivot_x, w.pivot_z, s, c, clipped);
            arp_pkg::AXIS_Z: turn_pair(vx, vy, w.pivot_x, w.pivot_y, s, c, clipped);
            default: ;
        endcase
        r.rotated_x = arp_pkg::COORD_W'(vx);
        r.rotated_y = arp_pkg::COORD_W'(vy);
        r.rotated_z = arp_pkg::COORD_W'(vz);
        r.saturated = clipped;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Word generation and driving
    // ---------------------------------------------------------------

    function automatic arp_pkg::t_in_word make_word(
        input logic [arp_pkg::OP_W-1:0]           op,
        input logic signed [arp_pkg::COORD_W-1:0] px,
        input logic signed [arp_pkg::COORD_W-1:0] py,
        input logic signed [arp_pkg::COORD_W-1:0] pz,
        input logic signed [arp_pkg::COORD_W-1:0] qx,
        input logic signed [arp_pkg::COORD_W-1:0] qy,
        input logic signed [arp_pkg::COORD_W-1:0] qz,
        input logic [arp_pkg::ANGLE_W-1:0]        ang);
        arp_pkg::t_in_word w;
        w.operation = op;
        w.point_x   = px;
        w.point_y   = py;
        w.point_z   = pz;
        w.pivot_x   = qx;
        w.pivot_y   = qy;
        w.pivot_z   = qz;
        w.angle     = ang;
        return w;
    endfunction

    // mix of full-range, near-limit and modest coordinates
    function automatic logic signed [arp_pkg::COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return C_MAX - arp_pkg::COORD_W'($urandom_range(0, 15));
            1:       return C_MIN + arp_pkg::COORD_W'($urandom_range(0, 15));
            2, 3:    return arp_pkg::COORD_W'($urandom_range(0, 32'h01FF_FFFF))
                            - 32'sh0100_0000;
            default: return arp_pkg::COORD_W'($urandom);
        endcase
    endfunction

    // pivot within about two units of the point
    function automatic logic signed [arp_pkg::COORD_W-1:0] near(
        input logic signed [arp_pkg::COORD_W-1:0] v);
        return v + arp_pkg::COORD_W'($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
    endfunction

    function automatic logic [arp_pkg::ANGLE_W-1:0] rand_angle();
        if ($urandom_range(0, 3) == 0) begin
            // quadrant boundaries and their neighbors
            return arp_pkg::ANGLE_W'($urandom_range(0, 3) * QTR_TURN
                                     + $urandom_range(0, 2) - 1);
        end
        return arp_pkg::ANGLE_W'($urandom_range(0, (1 << arp_pkg::ANGLE_W) - 1));
    endfunction

    function automatic arp_pkg::t_in_word random_word();
        arp_pkg::t_in_word w;
        w.operation = ($urandom_range(0, 9) == 0) ? arp_pkg::AXIS_NONE
                                                  : arp_pkg::OP_W'($urandom_range(0, 2));
        w.point_x   = rand_coord();
        w.point_y   = rand_coord();
        w.point_z   = rand_coord();
        if ($urandom_range(0, 3) == 0) begin
            w.pivot_x = near(w.point_x);
            w.pivot_y = near(w.point_y);
            w.pivot_z = near(w.point_z);
        end else begin
            w.pivot_x = rand_coord();
            w.pivot_y = rand_coord();
            w.pivot_z = rand_coord();
        end
        w.angle = rand_angle();
        return w;
    endfunction

    // drive one word at the falling edge, hold it until accepted
    task automatic send_word(input arp_pkg::t_in_word w);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_word  = w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        rotation_queue.push_back(predict_rotation(w));
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // output stall in random bursts, with quiet stretches
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                i_stall = 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
                i_stall = 1'b0;
            end else if (idle_on && $urandom_range(0, 31) == 0) begin
                repeat ($urandom_range(20, 60)) @(negedge i_clk);
            end
        end
    end

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string field,
                                   input logic [arp_pkg::COORD_W-1:0] want,
                                   input logic [arp_pkg::COORD_W-1:0] got);
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (rotation_queue.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h", $time, o_word);
                error_count++;
            end else begin
                want_word = rotation_queue.pop_front();
                if (o_word.rotated_x !== want_word.rotated_x)
                    report_mismatch("rotated_x", want_word.rotated_x, o_word.rotated_x);
                if (o_word.rotated_y !== want_word.rotated_y)
                    report_mismatch("rotated_y", want_word.rotated_y, o_word.rotated_y);
                if (o_word.rotated_z !== want_word.rotated_z)
                    report_mismatch("rotated_z", want_word.rotated_z, o_word.rotated_z);
                if (o_word.saturated !== want_word.saturated)
                    report_mismatch("saturated", arp_pkg::COORD_W'(want_word.saturated),
                                    arp_pkg::COORD_W'(o_word.saturated));
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // every axis code at zero, eighth and quarter turn
    task automatic test_axis_each();
        logic [arp_pkg::OP_W-1:0]    axes   [4] = '{arp_pkg::AXIS_X, arp_pkg::AXIS_Y,
                                                    arp_pkg::AXIS_Z, arp_pkg::AXIS_NONE};
        logic [arp_pkg::ANGLE_W-1:0] angles [3] = '{12'd0, 12'd512, 12'd1024};
        foreach (axes[i]) begin
            foreach (angles[j]) begin
                send_word(make_word(axes[i], 32'sh0001_8000, 32'shFFFD_C000, 32'sh0003_0000,
                                    32'sh0000_8000, 32'sh0000_8000, 32'shFFFF_0000,
                                    angles[j]));
            end
        end
    endtask

    // angles in the upper quadrants and at the wrap
    task automatic test_angle_wrap();
        logic [arp_pkg::ANGLE_W-1:0] angles [4] = '{12'd2048, 12'd3072, 12'd4095, 12'd1};
        foreach (angles[j]) begin
            send_word(make_word(arp_pkg::AXIS_Z, 32'sh0002_0000, 32'sh0001_0000,
                                32'sh0000_4000, 32'shFFFF_8000, 32'sh0000_0000,
                                32'sh0000_0000, angles[j]));
        end
    endtask

    // clipping in both directions, pass-through at the limits, all-zero and all-one words
    task automatic test_saturation();
        send_word(make_word(arp_pkg::AXIS_X, '0, C_MAX, C_MAX, '0, '0, '0, 12'd512));
        send_word(make_word(arp_pkg::AXIS_Y, C_MIN, '0, '0, C_MAX, '0, '0, 12'd2048));
        send_word(make_word(arp_pkg::AXIS_Z, C_MAX, C_MIN, '0, C_MIN, C_MAX, '0, 12'd2048));
        send_word(make_word(arp_pkg::AXIS_NONE, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX, C_MIN,
                            12'd4095));
        send_word(make_word(arp_pkg::AXIS_X, '0, '0, '0, '0, '0, '0, 12'd0));
        send_word(make_word(arp_pkg::AXIS_NONE, '1, '1, '1, '1, '1, '1, '1));
    endtask

    task automatic test_random_words(input int count);
        repeat (count) send_word(random_word());
    endtask

    // back-to-back words with no gaps and no stall
    task automatic test_steady_stream(input int count);
        idle_on = 1'b0;
        repeat (count) send_word(random_word());
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_word  = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_axis_each();
        test_angle_wrap();
        test_saturation();
        test_random_words(1800);
        test_steady_stream(200);

        while (rotation_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
